/* rtl/priority_counting_semaphore_macros.svh */
// Assertion macros shared by the semaphore checker.
`ifndef PRIORITY_COUNTING_SEMAPHORE_MACROS_SVH
`define PRIORITY_COUNTING_SEMAPHORE_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled in reset.
`define PCS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on clk and disabled in reset.
`define PCS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/pcs_pkg.sv */
// Package with the types, codes and sizes of the priority counting semaphore.
package pcs_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int LEN_W = $clog2(QUEUE_DEPTH + 1);

  localparam int IN_W = 24;
  localparam int OUT_W = 32;

  localparam logic [1:0] CMD_WAIT = 2'd0;
  localparam logic [1:0] CMD_TRYWAIT = 2'd1;
  localparam logic [1:0] CMD_POST = 2'd2;

  localparam logic [2:0] STAT_DONE = 3'd0;
  localparam logic [2:0] STAT_QUEUED = 3'd1;
  localparam logic [2:0] STAT_NOT_QUEUED = 3'd2;
  localparam logic [2:0] STAT_UNAVAIL = 3'd3;
  localparam logic [2:0] STAT_AT_MAX = 3'd4;

  localparam logic REG_MAX_COUNT = 1'b0;
  localparam logic REG_INITIAL_COUNT = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_SEARCH
  } state_t;

  typedef struct packed {
    logic enq;
    logic deq;
    logic [LEN_W-1:0] len;
    logic [IDX_W-1:0] sel_idx;
    logic [7:0] in_id;
    logic [7:0] in_prio;
  } cell_ctl_t;

  typedef struct packed {
    logic vld;
    logic [7:0] prio;
    logic [7:0] id;
    logic [IDX_W-1:0] idx;
  } best_t;

endpackage

/* rtl/pcs_cell.sv */
// One queue entry: holds a waiter and passes the best waiter so far to its neighbor.
module pcs_cell
  import pcs_pkg::*;
(
  input  logic             clk,
  input  logic [IDX_W-1:0] cell_idx,
  input  cell_ctl_t        ctl,
  input  logic [7:0]       nxt_id,
  input  logic [7:0]       nxt_prio,
  input  best_t            best_in,
  output logic [7:0]       id,
  output logic [7:0]       prio,
  output best_t            best_out
);

  logic [LEN_W-1:0] my_pos;
  logic occ;
  logic take_in;
  logic take_nxt;
  best_t best_next;

  assign my_pos = LEN_W'(cell_idx);
  assign occ = my_pos < ctl.len;
  assign take_in = ctl.enq && (my_pos == ctl.len);
  assign take_nxt = ctl.deq && (cell_idx >= ctl.sel_idx) && ((my_pos + LEN_W'(1)) < ctl.len);

  always_comb begin
    best_next = best_in;
    if (occ && (!best_in.vld || (prio > best_in.prio))) begin
      best_next.vld = 1'b1;
      best_next.prio = prio;
      best_next.id = id;
      best_next.idx = cell_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (take_in) begin
      id <= ctl.in_id;
      prio <= ctl.in_prio;
    end else if (take_nxt) begin
      id <= nxt_id;
      prio <= nxt_prio;
    end
    best_out <= best_next;
  end

endmodule

/* rtl/priority_counting_semaphore.sv */
// Top level of the counting semaphore with a priority-ordered wait queue.
// Wait, trywait, refused posts and posts without waiters give their result one cycle after
// acceptance. A post that wakes a waiter first searches the queue: the priority compare
// moves one cell per cycle down the chain of queue cells. One command is in flight at a time,
// so a new command is accepted only once the result of the last one has been taken.
// Reset sets the count limit to 1, the preset count and the count to 0 and empties the queue.
module priority_counting_semaphore
  import pcs_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,  // task_id[7:0], task_valid[8], task_priority[16:9]
  input  logic [1:0]       s_tuser,  // cmd[1:0]
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata,  // status[2:0], woken_valid[3], woken_task_id[11:4],
                                     // current_count[19:12], waiters[24:20]
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic             cfg_index,
  input  logic [7:0]       cfg_data
);

  logic [7:0] count_limit;
  logic [7:0] count_preset;
  logic [7:0] sem_count;
  logic [7:0] sem_count_next;
  logic [LEN_W-1:0] queue_len;
  logic [LEN_W-1:0] queue_len_next;
  logic [IDX_W-1:0] cnt;
  logic [IDX_W-1:0] cnt_next;
  state_t state;
  state_t state_next;
  logic out_load;
  logic [2:0] status;
  logic woken_valid;
  logic [7:0] wake_id;
  logic [4:0] waiters_out;
  logic accept;
  logic [1:0] cmd;
  logic [7:0] task_id;
  logic task_valid;
  logic [7:0] task_priority;
  cell_ctl_t ctl;
  best_t best [QUEUE_DEPTH];
  logic [7:0] c_id [QUEUE_DEPTH];
  logic [7:0] c_prio [QUEUE_DEPTH];

  assign cmd = s_tuser;
  assign task_id = s_tdata[7:0];
  assign task_valid = s_tdata[8];
  assign task_priority = s_tdata[16:9];
  assign s_tready = (state == ST_IDLE) && !m_tvalid;
  assign cfg_ready = 1'b1;
  assign accept = s_tvalid && s_tready;

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    logic [7:0] n_id;
    logic [7:0] n_prio;
    best_t b_in;
    if (g < QUEUE_DEPTH - 1) begin : g_mid
      assign n_id = c_id[g+1];
      assign n_prio = c_prio[g+1];
    end else begin : g_last
      assign n_id = '0;
      assign n_prio = '0;
    end
    if (g == 0) begin : g_head
      assign b_in = '0;
    end else begin : g_chain
      assign b_in = best[g-1];
    end
    pcs_cell u_cell (
      .clk      (clk),
      .cell_idx (IDX_W'(g)),
      .ctl      (ctl),
      .nxt_id   (n_id),
      .nxt_prio (n_prio),
      .best_in  (b_in),
      .id       (c_id[g]),
      .prio     (c_prio[g]),
      .best_out (best[g])
    );
  end

  always_comb begin
    state_next = state;
    cnt_next = cnt;
    sem_count_next = sem_count;
    queue_len_next = queue_len;
    out_load = 1'b0;
    status = STAT_DONE;
    woken_valid = 1'b0;
    wake_id = '0;
    ctl.enq = 1'b0;
    ctl.deq = 1'b0;
    ctl.len = queue_len;
    ctl.sel_idx = best[QUEUE_DEPTH-1].idx;
    ctl.in_id = task_id;
    ctl.in_prio = task_priority;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          out_load = 1'b1;
          case (cmd)
            CMD_WAIT: begin
              if (sem_count != 8'd0) begin
                sem_count_next = sem_count - 8'd1;
              end else if (task_valid && (queue_len < LEN_W'(QUEUE_DEPTH))) begin
                ctl.enq = 1'b1;
                queue_len_next = queue_len + LEN_W'(1);
                status = STAT_QUEUED;
              end else begin
                status = STAT_NOT_QUEUED;
              end
            end
            CMD_TRYWAIT: begin
              if (sem_count != 8'd0) begin
                sem_count_next = sem_count - 8'd1;
              end else begin
                status = STAT_UNAVAIL;
              end
            end
            CMD_POST: begin
              if (sem_count >= count_limit) begin
                status = STAT_AT_MAX;
              end else if (queue_len != '0) begin
                out_load = 1'b0;
                state_next = ST_SEARCH;
                cnt_next = IDX_W'(QUEUE_DEPTH - 1);
              end else begin
                sem_count_next = sem_count + 8'd1;
              end
            end
            default: status = STAT_UNAVAIL;
          endcase
        end
      end
      ST_SEARCH: begin
        if (cnt == '0) begin
          ctl.deq = 1'b1;
          queue_len_next = queue_len - LEN_W'(1);
          woken_valid = 1'b1;
          wake_id = best[QUEUE_DEPTH-1].id;
          out_load = 1'b1;
          state_next = ST_IDLE;
        end else begin
          cnt_next = cnt - IDX_W'(1);
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign waiters_out = 5'(queue_len_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt <= '0;
      count_limit <= 8'd1;
      count_preset <= 8'd0;
      sem_count <= 8'd0;
      queue_len <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
      queue_len <= queue_len_next;
      if (cfg_valid && cfg_ready && (cfg_index == REG_INITIAL_COUNT)) begin
        sem_count <= (cfg_data > count_limit) ? count_limit : cfg_data;
      end else begin
        sem_count <= sem_count_next;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MAX_COUNT: count_limit <= cfg_data;
          REG_INITIAL_COUNT: count_preset <= cfg_data;
          default: ;
        endcase
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {7'd0, waiters_out, sem_count_next, wake_id, woken_valid, status};
    end
  end

endmodule

/* rtl/pcs_checker.sv */
// Port-level checker for the semaphore and the bind that attaches it.
`include "priority_counting_semaphore_macros.svh"

module pcs_checker
  import pcs_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             s_tvalid,
  input logic             s_tready,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata
);

  // A held result word must not change under backpressure.
  `PCS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  // Only one command is in flight: no new word while a result waits.
  `PCS_ASSERT_NOW(a_one_in_flight, m_tvalid, !s_tready)
  `PCS_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
  // A wake-up is always a completed post; without one the id reads zero.
  `PCS_ASSERT_NOW(a_wake_done, m_tvalid && m_tdata[3], m_tdata[2:0] == STAT_DONE)
  `PCS_ASSERT_NOW(a_no_wake_id, m_tvalid && !m_tdata[3], m_tdata[11:4] == 8'd0)

endmodule

bind priority_counting_semaphore pcs_checker u_pcs_checker (.*);

/* tb/tb_priority_counting_semaphore.sv */
// Self-checking testbench for the priority counting semaphore with its wait queue.
`timescale 1ns / 1ps

module tb_priority_counting_semaphore;
  import pcs_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int PHASES = 10;
  localparam int PHASE_WORDS = 115;

  typedef struct {
    logic [2:0] status;
    logic       woken;
    logic [7:0] wake_id;
    logic [7:0] count;
    logic [4:0] waiters;
  } sem_result_t;

  class sem_tracker;
    logic [7:0]  limit_reg;
    logic [7:0]  preset_reg;
    logic [7:0]  count;
    logic [7:0]  wait_ids[QUEUE_DEPTH];
    logic [7:0]  wait_prios[QUEUE_DEPTH];
    int          depth;
    sem_result_t pending_results[$];
    int          error_count;

    function new();
      limit_reg = 8'd1;
      preset_reg = 8'd0;
      count = 8'd0;
      depth = 0;
      error_count = 0;
    endfunction

    function void set_register(logic idx, logic [7:0] val);
      if (idx == REG_MAX_COUNT) begin
        limit_reg = val;
      end else begin
        preset_reg = val;
        count = (val > limit_reg) ? limit_reg : val;
      end
    endfunction

    function void apply_command(logic [1:0] cmd, logic [7:0] id, logic vld, logic [7:0] prio);
      sem_result_t r;
      int best;
      r.status = STAT_DONE;
      r.woken = 1'b0;
      r.wake_id = 8'd0;
      case (cmd)
        CMD_WAIT: begin
          if (count != 0) begin
            count--;
          end else if (vld && depth < QUEUE_DEPTH) begin
            wait_ids[depth] = id;
            wait_prios[depth] = prio;
            depth++;
            r.status = STAT_QUEUED;
          end else begin
            r.status = STAT_NOT_QUEUED;
          end
        end
        CMD_TRYWAIT: begin
          if (count != 0) count--;
          else r.status = STAT_UNAVAIL;
        end
        CMD_POST: begin
          if (count >= limit_reg) begin
            r.status = STAT_AT_MAX;
          end else if (depth > 0) begin
            best = 0;
            for (int i = 1; i < depth; i++) begin
              if (wait_prios[i] > wait_prios[best]) best = i;
            end
            r.woken = 1'b1;
            r.wake_id = wait_ids[best];
            for (int i = best; i < depth - 1; i++) begin
              wait_ids[i] = wait_ids[i + 1];
              wait_prios[i] = wait_prios[i + 1];
            end
            depth--;
          end else begin
            count++;
          end
        end
        default: r.status = STAT_UNAVAIL;
      endcase
      r.count = count;
      r.waiters = depth[4:0];
      pending_results.push_back(r);
    endfunction

    function void check_field(string label, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
        error_count++;
      end
    endfunction

    function void compare_result(logic [OUT_W-1:0] word);
      sem_result_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual %h", $time, word);
        error_count++;
        return;
      end
      want = pending_results.pop_front();
      check_field("status", want.status, word[2:0]);
      check_field("woken_valid", want.woken, word[3]);
      check_field("woken_task_id", want.wake_id, word[11:4]);
      check_field("current_count", want.count, word[19:12]);
      check_field("waiters", want.waiters, word[24:20]);
      check_field("padding", 8'd0, word[31:25]);
    endfunction
  endclass

  logic             clk;
  logic             rst;
  logic             s_tvalid;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata;
  logic [1:0]       s_tuser;
  logic             m_tvalid;
  logic             m_tready;
  logic [OUT_W-1:0] m_tdata;
  logic             cfg_valid;
  logic             cfg_ready;
  logic             cfg_index;
  logic [7:0]       cfg_data;

  sem_tracker board = new();
  int send_gap_pct = 20;
  int stall_pct = 25;

  priority_counting_semaphore dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.compare_result(m_tdata);
  end

  task automatic send_command(input logic [1:0] cmd, input logic [7:0] id, input logic vld,
                              input logic [7:0] prio);
    if (send_gap_pct != 0 && $urandom_range(1, 100) <= send_gap_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= {7'd0, prio, vld, id};
    do @(posedge clk); while (!s_tready);
    board.apply_command(cmd, id, vld, prio);
  endtask

  task automatic random_command(input int post_pct);
    int roll;
    logic [1:0] cmd;
    logic [7:0] prio;
    roll = $urandom_range(1, 100);
    if (roll <= 2) cmd = CMD_UNUSED;
    else if (roll <= 2 + post_pct) cmd = CMD_POST;
    else if (roll <= 17 + post_pct) cmd = CMD_TRYWAIT;
    else cmd = CMD_WAIT;
    prio = $urandom_range(0, 1) ? 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 255));
    send_command(cmd, 8'($urandom_range(0, 255)), $urandom_range(0, 7) != 0, prio);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (board.pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_register(input logic idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    board.set_register(idx, val);
  endtask

  task automatic configure(input logic [7:0] limit, input logic [7:0] preset);
    write_register(REG_MAX_COUNT, limit);
    write_register(REG_INITIAL_COUNT, preset);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [7:0] limit_plan[PHASES] = '{8'd1, 8'd255, 8'd2, 8'd0, 8'd3,
                                       8'd255, 8'd1, 8'd0, 8'd8, 8'd4};
    logic [7:0] preset_plan[PHASES] = '{8'd0, 8'd255, 8'd1, 8'd0, 8'd0,
                                        8'd0, 8'd1, 8'd255, 8'd0, 8'd2};
    int post_plan[PHASES] = '{35, 25, 40, 30, 45, 30, 40, 35, 38, 40};
    logic [7:0] limit;
    logic [7:0] preset;

    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tuser <= CMD_WAIT;
    cfg_valid <= 1'b0;
    cfg_index <= REG_MAX_COUNT;
    cfg_data <= 8'd0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    send_command(CMD_TRYWAIT, 8'h11, 1'b1, 8'h00);
    send_command(CMD_WAIT, 8'h22, 1'b0, 8'h40);
    send_command(CMD_UNUSED, 8'h33, 1'b1, 8'h01);
    send_command(CMD_POST, 8'h44, 1'b1, 8'h02);
    send_command(CMD_POST, 8'h55, 1'b1, 8'h03);
    send_command(CMD_WAIT, 8'h66, 1'b1, 8'h04);
    send_command(CMD_WAIT, 8'hFF, 1'b1, 8'h00);
    send_command(CMD_WAIT, 8'h00, 1'b1, 8'hFF);
    send_command(CMD_WAIT, 8'hA5, 1'b1, 8'h80);
    send_command(CMD_WAIT, 8'h5A, 1'b1, 8'hFF);
    send_command(CMD_TRYWAIT, 8'h77, 1'b1, 8'h05);
    repeat (5) send_command(CMD_POST, 8'h88, 1'b1, 8'h06);
    drain();
    configure(8'd1, 8'd200);
    send_command(CMD_TRYWAIT, 8'h99, 1'b1, 8'h07);
    drain();
    configure(8'd255, 8'd255);
    send_command(CMD_POST, 8'hAA, 1'b1, 8'h08);
    send_command(CMD_TRYWAIT, 8'hBB, 1'b1, 8'h09);
    drain();

    for (int phase = 0; phase < PHASES; phase++) begin
      limit = (limit_plan[phase] == 0) ? 8'($urandom_range(1, 255)) : limit_plan[phase];
      preset = (phase == 3) ? 8'($urandom_range(0, 255)) : preset_plan[phase];
      configure(limit, preset);
      send_gap_pct = (phase == 2 || phase == PHASES - 1) ? 0 : 20;
      stall_pct = (phase == 5 || phase == PHASES - 1) ? 0 : 25;
      for (int n = 0; n < PHASE_WORDS; n++) random_command(post_plan[phase]);
      drain();
    end

    repeat (20) @(posedge clk);
    if (board.error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
